/* src/zrv_pkg.sv */
// Shared types and constants for the zero-run visibility row decoder.
`default_nettype none
package zrv_pkg;

  localparam int LEAF_W  = 13;
  localparam int ROW_W   = 10;
  localparam int WORD_W  = 64;
  localparam int LANES   = 8;
  localparam int FILL_W  = 3;
  localparam int CNT_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int RESULT_CAP_LEAVES = 4096;
  localparam logic [7:0] ALL_ONES_BYTE = 8'hff;
  localparam logic [ADDR_W-1:0] REG_LEAF_COUNT = 3'd0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } zrv_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } zrv_cmd_t;

  typedef struct packed {
    logic run_zero;
    logic last_chunk;
    logic slot_free;
  } zrv_status_t;

endpackage
`default_nettype wire

/* src/zrv_if.sv */
// Valid/ready channel interfaces for compressed input beats and result beats.
`default_nettype none
interface zrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       no_vis;

  modport source (output valid, data_byte, no_vis, input ready);
  modport sink   (input valid, data_byte, no_vis, output ready);
endinterface

interface zrv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_word;
  logic [3:0]  byte_count;
  logic        row_done;
  logic        overrun;

  modport source (output valid, row_word, byte_count, row_done, overrun, input ready);
  modport sink   (input valid, row_word, byte_count, row_done, overrun, output ready);
endinterface
`default_nettype wire

/* src/zrv_ctrl.sv */
// Controller: accepts one input beat, then steps the datapath through its run.
`default_nettype none
module zrv_ctrl
  import zrv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  zrv_status_t      status,
  output zrv_cmd_t         cmd
);

  zrv_state_t state_r;
  zrv_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.run_zero) begin
          state_nxt = ST_IDLE;
        end else if (status.slot_free && status.last_chunk) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step = !status.run_zero && status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/zrv_dpath.sv */
// Datapath: run setup, byte-lane packing, row position and the result register.
`default_nettype none
module zrv_dpath
  import zrv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  zrv_cmd_t              cmd,
  input  wire logic             clear,
  input  wire logic [ROW_W-1:0] row_len,
  input  wire logic [7:0]       data_byte,
  input  wire logic             no_vis,
  output zrv_status_t           status,
  zrv_out_if.source             out_bus
);

  logic              await_r,  await_nxt;
  logic [ROW_W-1:0]  done_r,   done_nxt;
  logic [WORD_W-1:0] buf_r,    buf_nxt;
  logic [FILL_W-1:0] fill_r,   fill_nxt;
  logic [ROW_W-1:0]  run_r,    run_nxt;
  logic [7:0]        val_r,    val_nxt;
  logic              cut_r,    cut_nxt;
  logic              ovld_r,   ovld_nxt;
  logic [WORD_W-1:0] oword_r,  oword_nxt;
  logic [CNT_W-1:0]  ocnt_r,   ocnt_nxt;
  logic              odone_r,  odone_nxt;
  logic              oover_r,  oover_nxt;

  logic [CNT_W-1:0]  space;
  logic [ROW_W-1:0]  row_left;
  logic [CNT_W-1:0]  k_run;
  logic [CNT_W-1:0]  k;
  logic [CNT_W:0]    lane_end;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  new_fill;
  logic [ROW_W-1:0]  done_sum;
  logic              row_end;
  logic              emit;

  assign space    = CNT_W'(LANES) - {1'b0, fill_r};
  assign row_left = row_len - done_r;
  assign k_run    = (run_r < ROW_W'(space)) ? run_r[CNT_W-1:0] : space;
  assign k        = (row_left < ROW_W'(k_run)) ? row_left[CNT_W-1:0] : k_run;
  assign lane_end = {2'b00, fill_r} + {1'b0, k};
  assign new_fill = {1'b0, fill_r} + k;
  assign done_sum = done_r + ROW_W'(k);
  assign row_end  = (done_sum == row_len);
  assign emit     = (new_fill == CNT_W'(LANES)) || row_end;

  always_comb begin
    word = buf_r;
    for (int j = 0; j < LANES; j++) begin
      if ((CNT_W'(j) >= {1'b0, fill_r}) && ((CNT_W+1)'(j) < lane_end)) begin
        word[j*8 +: 8] = val_r;
      end
    end
  end

  assign status.run_zero   = (run_r == '0);
  assign status.last_chunk = (run_r == ROW_W'(k));
  assign status.slot_free  = !ovld_r || out_bus.ready;

  always_comb begin
    await_nxt = await_r;
    done_nxt  = done_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    run_nxt   = run_r;
    val_nxt   = val_r;
    cut_nxt   = cut_r;
    ovld_nxt  = ovld_r && !out_bus.ready;
    oword_nxt = oword_r;
    ocnt_nxt  = ocnt_r;
    odone_nxt = odone_r;
    oover_nxt = oover_r;

    if (clear) begin
      await_nxt = 1'b0;
      done_nxt  = '0;
      buf_nxt   = '0;
      fill_nxt  = '0;
      run_nxt   = '0;
    end else if (cmd.load) begin
      cut_nxt = 1'b0;
      if (no_vis) begin
        await_nxt = 1'b0;
        done_nxt  = '0;
        buf_nxt   = '0;
        fill_nxt  = '0;
        run_nxt   = row_len;
        val_nxt   = ALL_ONES_BYTE;
      end else if (await_r) begin
        await_nxt = 1'b0;
        val_nxt   = 8'h00;
        if (ROW_W'(data_byte) > row_left) begin
          run_nxt = row_left;
          cut_nxt = 1'b1;
        end else begin
          run_nxt = ROW_W'(data_byte);
        end
      end else if (data_byte != 8'h00) begin
        run_nxt = ROW_W'(1);
        val_nxt = data_byte;
      end else begin
        await_nxt = 1'b1;
        run_nxt   = '0;
      end
    end else if (cmd.step) begin
      run_nxt = run_r - ROW_W'(k);
      if (emit) begin
        ovld_nxt  = 1'b1;
        oword_nxt = word;
        ocnt_nxt  = new_fill;
        odone_nxt = row_end;
        oover_nxt = row_end && cut_r;
        buf_nxt   = '0;
        fill_nxt  = '0;
        done_nxt  = row_end ? '0 : done_sum;
      end else begin
        buf_nxt  = word;
        fill_nxt = new_fill[FILL_W-1:0];
        done_nxt = done_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      done_r  <= '0;
      buf_r   <= '0;
      fill_r  <= '0;
      run_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      await_r <= await_nxt;
      done_r  <= done_nxt;
      buf_r   <= buf_nxt;
      fill_r  <= fill_nxt;
      run_r   <= run_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    cut_r   <= cut_nxt;
    oword_r <= oword_nxt;
    ocnt_r  <= ocnt_nxt;
    odone_r <= odone_nxt;
    oover_r <= oover_nxt;
  end

  assign out_bus.valid      = ovld_r;
  assign out_bus.row_word   = oword_r;
  assign out_bus.byte_count = ocnt_r;
  assign out_bus.row_done   = odone_r;
  assign out_bus.overrun    = oover_r;

endmodule
`default_nettype wire

/* src/zero_run_visibility_decoder.sv */
// Zero-run visibility row decoder top level: config register and module wiring.
//
// Input channel in_bus carries one compressed byte per beat (data_byte, no_vis).
// A nonzero byte is a literal, a zero byte is a marker whose following byte is a
// zero-run count, and no_vis emits a full row of 0xff. Result beats on out_bus
// carry up to eight decoded bytes (low byte first), the valid byte count, a
// row-end mark and an overrun mark for a run cut off at the row end.
// Timing: a beat is taken in the idle state, then its bytes are packed up to eight
// per cycle, limited by the free lanes of the packing word and the row end.
// A literal or marker beat is loaded, then passes through the run state; a
// run or no_vis beat is loaded, then packed chunk by chunk (a run of zero
// still passes through the run state); a row is at most 512 bytes. A result
// appears in the output register the cycle after the chunk that closes its
// word and is held there; no chunk advances while the register is full and
// not taken, but the next input beat is taken while a result waits.
// Reset (rst_n low, synchronous) empties the row in progress and the output
// register and sets leaf_count to 1. Writing leaf_count (APB, any address with
// paddr[2] low) drops the row in progress without output.
`default_nettype none
module zero_run_visibility_decoder
  import zrv_pkg::*;
#(
  parameter int MAX_LEAVES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  zrv_in_if.sink                 in_bus,
  zrv_out_if.source              out_bus,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int LEAF_LIMIT =
    (MAX_LEAVES < RESULT_CAP_LEAVES) ? MAX_LEAVES : RESULT_CAP_LEAVES;

  logic [LEAF_W-1:0] leaf_count_r, leaf_count_nxt;
  logic              cfg_wr;
  logic [LEAF_W-1:0] leaves;
  logic [LEAF_W-1:0] leaves_rnd;
  logic [ROW_W-1:0]  row_len;
  zrv_cmd_t          cmd;
  zrv_status_t       status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[ADDR_W-1] == REG_LEAF_COUNT[ADDR_W-1]);
  assign cfg_prdata = (cfg_paddr[ADDR_W-1] == REG_LEAF_COUNT[ADDR_W-1]) ?
                      {{(32-LEAF_W){1'b0}}, leaf_count_r} : 32'h0;

  assign leaf_count_nxt = cfg_wr ? cfg_pwdata[LEAF_W-1:0] : leaf_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= LEAF_W'(1);
    end else begin
      leaf_count_r <= leaf_count_nxt;
    end
  end

  always_comb begin
    if (leaf_count_r == '0) begin
      leaves = LEAF_W'(1);
    end else if (leaf_count_r > LEAF_W'(LEAF_LIMIT)) begin
      leaves = LEAF_W'(LEAF_LIMIT);
    end else begin
      leaves = leaf_count_r;
    end
  end

  assign leaves_rnd = leaves + LEAF_W'(7);
  assign row_len    = leaves_rnd[LEAF_W-1:3];

  zrv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .status   (status),
    .cmd      (cmd)
  );

  zrv_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .clear     (cfg_wr),
    .row_len   (row_len),
    .data_byte (in_bus.data_byte),
    .no_vis    (in_bus.no_vis),
    .status    (status),
    .out_bus   (out_bus)
  );

endmodule
`default_nettype wire
